// ===== rtl/ccr_pkg.sv =====
package ccr_pkg;

    localparam int unsigned DataWidth = 32;
    localparam int unsigned AddrWidth = 16;

    // register offsets after the low two bits are dropped
    localparam logic [AddrWidth-1:0] ADDR_STATUS = 16'h0000;
    localparam logic [AddrWidth-1:0] ADDR_DATA0  = 16'h0004;
    localparam logic [AddrWidth-1:0] ADDR_DATA1  = 16'h0008;
    localparam logic [AddrWidth-1:0] ADDR_IDENT  = 16'h000C;
    localparam logic [AddrWidth-1:0] ADDR_LOCK   = 16'h0010;

    localparam logic [DataWidth-1:0] ID_WORD     = 32'h5343_7632;
    localparam logic [DataWidth-1:0] MAGIC_ONE   = 32'h5F55_4E4C;
    localparam logic [DataWidth-1:0] MAGIC_TWO   = 32'h4F43_4B5F;
    localparam logic [DataWidth-1:0] STATUS_BUSY = 32'h4000_0000;
    localparam logic [DataWidth-1:0] LOCK_ALL    = 32'hFFFF_FFFF;

    // command codes written to the status register
    localparam logic [DataWidth-1:0] CMD_CFG_GET    = 32'h0000_0063;
    localparam logic [DataWidth-1:0] CMD_CFG_SET    = 32'h0000_0043;
    localparam logic [DataWidth-1:0] CMD_INIT       = 32'h0000_0069;
    localparam logic [DataWidth-1:0] CMD_SET_SECTOR = 32'h0000_0049;

    // sub-codes
    localparam logic [DataWidth-1:0] CFG_ROM_WR_EN  = 32'd1;
    localparam logic [DataWidth-1:0] CFG_QUERY_A    = 32'd3;
    localparam logic [DataWidth-1:0] CFG_QUERY_B    = 32'd6;
    localparam logic [DataWidth-1:0] INIT_PLAIN_A   = 32'd0;
    localparam logic [DataWidth-1:0] INIT_PLAIN_B   = 32'd1;
    localparam logic [DataWidth-1:0] INIT_SWAP_ON   = 32'd4;
    localparam logic [DataWidth-1:0] INIT_SWAP_OFF  = 32'd5;

    typedef enum logic
    {
        ACT_READ  = 1'b0,
        ACT_WRITE = 1'b1
    } action_t;

    typedef struct packed
    {
        logic                 action;
        logic [AddrWidth-1:0] reg_address;
        logic [DataWidth-1:0] write_data;
    } req_t;

    typedef struct packed
    {
        logic [DataWidth-1:0] read_data;
        logic                 rom_write_enable;
        logic                 byteswap_mode;
        logic [DataWidth-1:0] sd_sector_out;
    } rsp_t;

endpackage

// ===== rtl/ccr_req_if.sv =====
interface ccr_req_if;
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic [ccr_pkg::AddrWidth-1:0]  reg_address;
    logic [ccr_pkg::DataWidth-1:0]  write_data;

    modport source (output valid, output action, output reg_address, output write_data,
                    input ready);
    modport sink   (input valid, input action, input reg_address, input write_data,
                    output ready);
endinterface

// ===== rtl/ccr_rsp_if.sv =====
interface ccr_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ccr_pkg::DataWidth-1:0]  read_data;
    logic                           rom_write_enable;
    logic                           byteswap_mode;
    logic [ccr_pkg::DataWidth-1:0]  sd_sector_out;

    modport source (output valid, output read_data, output rom_write_enable,
                    output byteswap_mode, output sd_sector_out, input ready);
    modport sink   (input valid, input read_data, input rom_write_enable,
                    input byteswap_mode, input sd_sector_out, output ready);
endinterface

// ===== rtl/ccr_regfile.sv =====
module ccr_regfile
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  ccr_pkg::req_t   access,
    output ccr_pkg::rsp_t   result
);

    logic                           unlocked_reg, unlocked_next;
    logic                           unlock_step_reg, unlock_step_next;
    logic [ccr_pkg::DataWidth-1:0]  status_reg, status_next;
    logic [ccr_pkg::DataWidth-1:0]  data0_reg, data0_next;
    logic [ccr_pkg::DataWidth-1:0]  data1_reg, data1_next;
    logic                           rom_flag_reg, rom_flag_next;
    logic                           swap_flag_reg, swap_flag_next;
    logic [ccr_pkg::DataWidth-1:0]  sector_reg, sector_next;

    logic [ccr_pkg::AddrWidth-1:0]  addr;
    logic                           is_write;
    logic [ccr_pkg::DataWidth-1:0]  rd;

    assign addr     = {access.reg_address[ccr_pkg::AddrWidth-1:2], 2'b00};
    assign is_write = (ccr_pkg::action_t'(access.action) == ccr_pkg::ACT_WRITE);

    always_comb
    begin
        unlocked_next    = unlocked_reg;
        unlock_step_next = unlock_step_reg;
        status_next      = status_reg;
        data0_next       = data0_reg;
        data1_next       = data1_reg;
        rom_flag_next    = rom_flag_reg;
        swap_flag_next   = swap_flag_reg;
        sector_next      = sector_reg;
        rd               = '0;

        if (is_write)
        begin
            unique case (addr)
                ccr_pkg::ADDR_STATUS:
                begin
                    if (unlocked_reg)
                    begin
                        // busy until the command says otherwise
                        status_next = ccr_pkg::STATUS_BUSY;
                        unique case (access.write_data)
                            ccr_pkg::CMD_CFG_GET:
                            begin
                                if (data0_reg == ccr_pkg::CFG_ROM_WR_EN)
                                begin
                                    data1_next  = {31'd0, rom_flag_reg};
                                    status_next = '0;
                                end
                                else if (data0_reg == ccr_pkg::CFG_QUERY_A ||
                                         data0_reg == ccr_pkg::CFG_QUERY_B)
                                begin
                                    data1_next  = '0;
                                    status_next = '0;
                                end
                            end
                            ccr_pkg::CMD_CFG_SET:
                            begin
                                if (data0_reg == ccr_pkg::CFG_ROM_WR_EN)
                                begin
                                    data1_next    = {31'd0, rom_flag_reg};
                                    rom_flag_next = (data1_reg != '0);
                                    status_next   = '0;
                                end
                            end
                            ccr_pkg::CMD_INIT:
                            begin
                                if (data1_reg == ccr_pkg::INIT_PLAIN_A ||
                                    data1_reg == ccr_pkg::INIT_PLAIN_B)
                                begin
                                    status_next = '0;
                                end
                                else if (data1_reg == ccr_pkg::INIT_SWAP_ON)
                                begin
                                    swap_flag_next = 1'b1;
                                    status_next    = '0;
                                end
                                else if (data1_reg == ccr_pkg::INIT_SWAP_OFF)
                                begin
                                    swap_flag_next = 1'b0;
                                    status_next    = '0;
                                end
                            end
                            ccr_pkg::CMD_SET_SECTOR:
                            begin
                                sector_next = data0_reg;
                                status_next = '0;
                            end
                            default:
                            begin
                                // unknown or transfer command: stays busy
                            end
                        endcase
                    end
                end
                ccr_pkg::ADDR_DATA0:
                begin
                    if (unlocked_reg)
                    begin
                        data0_next = access.write_data;
                    end
                end
                ccr_pkg::ADDR_DATA1:
                begin
                    if (unlocked_reg)
                    begin
                        data1_next = access.write_data;
                    end
                end
                ccr_pkg::ADDR_LOCK:
                begin
                    priority if (access.write_data == ccr_pkg::LOCK_ALL)
                    begin
                        unlocked_next = 1'b0;
                    end
                    else if (access.write_data == ccr_pkg::MAGIC_ONE)
                    begin
                        unlock_step_next = 1'b1;
                    end
                    else if (access.write_data == ccr_pkg::MAGIC_TWO)
                    begin
                        if (unlock_step_reg)
                        begin
                            unlocked_next    = 1'b1;
                            unlock_step_next = 1'b0;
                        end
                    end
                    else
                    begin
                        unlock_step_next = 1'b0;
                    end
                end
                default:
                begin
                    // identifier and unmapped offsets ignore writes
                end
            endcase
        end
        else if (unlocked_reg)
        begin
            unique case (addr)
                ccr_pkg::ADDR_STATUS: rd = status_reg;
                ccr_pkg::ADDR_DATA0:  rd = data0_reg;
                ccr_pkg::ADDR_DATA1:  rd = data1_reg;
                ccr_pkg::ADDR_IDENT:  rd = ccr_pkg::ID_WORD;
                default:              rd = '0;
            endcase
        end
    end

    // flags are shown as they stand after this beat
    assign result.read_data        = rd;
    assign result.rom_write_enable = rom_flag_next;
    assign result.byteswap_mode    = swap_flag_next;
    assign result.sd_sector_out    = sector_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unlocked_reg    <= 1'b0;
            unlock_step_reg <= 1'b0;
            status_reg      <= '0;
            data0_reg       <= '0;
            data1_reg       <= '0;
            rom_flag_reg    <= 1'b0;
            swap_flag_reg   <= 1'b0;
            sector_reg      <= '0;
        end
        else if (fire)
        begin
            unlocked_reg    <= unlocked_next;
            unlock_step_reg <= unlock_step_next;
            status_reg      <= status_next;
            data0_reg       <= data0_next;
            data1_reg       <= data1_next;
            rom_flag_reg    <= rom_flag_next;
            swap_flag_reg   <= swap_flag_next;
            sector_reg      <= sector_next;
        end
    end

endmodule

// ===== rtl/cartridge_command_registers.sv =====
// cartridge command register front end
//
// req channel (sink): one beat per bus access; action selects read or write,
// reg_address is a byte offset (low two bits ignored), write_data is the
// value of a write. rsp channel (source): exactly one beat per access, in
// order, with read_data and the current rom write, byte swap and sd sector
// state as it stands after that access.
//
// path: each accepted request beat is held in the input register, then the
// register file update is written into the response register and raises
// rsp.valid. throughput: one access per cycle while rsp.ready keeps the
// pipeline moving; the decode/update is a combinational step between them.
//
// reset (rst_n low, asynchronous) locks the registers, clears all register
// file state and empties both pipeline registers.
//
// when rsp.ready is low the response register holds its beat; the input
// register still takes one more access, then req.ready drops until the
// response is taken. no state changes while the pipeline is held.
module cartridge_command_registers
(
    input  logic        clk,
    input  logic        rst_n,
    ccr_req_if.sink     req,
    ccr_rsp_if.source   rsp
);

    // input register stage
    logic           in_valid_reg;
    ccr_pkg::req_t  in_data_reg;

    // response register stage
    logic           out_valid_reg;
    ccr_pkg::rsp_t  out_data_reg;

    logic           advance;
    logic           req_fire;
    logic           exec;
    ccr_pkg::rsp_t  result;

    // the response register can take a new beat when empty or being drained
    assign advance  = !out_valid_reg || rsp.ready;
    assign req.ready = !in_valid_reg || advance;
    assign req_fire = req.valid && req.ready;
    // the registered access is executed as it moves into the response register
    assign exec     = in_valid_reg && advance;

    ccr_regfile u_regfile
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (exec),
        .access (in_data_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            in_data_reg.action      <= req.action;
            in_data_reg.reg_address <= req.reg_address;
            in_data_reg.write_data  <= req.write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            out_data_reg <= result;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.read_data        = out_data_reg.read_data;
    assign rsp.rom_write_enable = out_data_reg.rom_write_enable;
    assign rsp.byteswap_mode    = out_data_reg.byteswap_mode;
    assign rsp.sd_sector_out    = out_data_reg.sd_sector_out;

endmodule

// ===== rtl/ccr_checker.sv =====
module ccr_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic                           req_ready,
    input  logic                           rsp_valid,
    input  logic                           rsp_ready,
    input  logic [ccr_pkg::DataWidth-1:0]  rsp_read_data,
    input  logic [ccr_pkg::DataWidth-1:0]  rsp_sd_sector_out
);

    // a stalled response keeps its beat
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) &&
                                    $stable(rsp_sd_sector_out))
        else $error("stalled response changed");

    // with the response register empty the pipeline can always take a beat
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request stalled with empty response register");

    // after an accepted access has passed the input and response registers, rsp_valid is high
    a_accept_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> ##2 rsp_valid)
        else $error("accepted access produced no response");

endmodule

bind cartridge_command_registers ccr_checker u_ccr_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_read_data     (rsp.read_data),
    .rsp_sd_sector_out (rsp.sd_sector_out)
);
